/* rtl/core/kdlpr_pkg.sv */
// Shared types and constants for the key debounce block with long press and auto-repeat.
// No dependencies; imported by the top-level module and its testbench.
`timescale 1ns / 1ps
`default_nettype none

package kdlpr_pkg;

  // Width of the debounce, long-press and repeat countdowns.
  localparam int COUNT_BITS = 24;
  // Width of the tick-count configuration registers.
  localparam int CFG_BITS   = 24;
  localparam int MARKER_BITS = 32;

  // APB port geometry: five 32-bit registers at byte addresses 4*i.
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 5;
  localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

  // Stream word widths.
  localparam int IN_TDATA_BITS  = 8;
  localparam int OUT_TDATA_BITS = 40;
  localparam int OUT_TUSER_BITS = 2;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [CFG_BITS-1:0]   cfg_ticks_t;

  // Kind of event reported on the result channel.
  typedef enum logic [OUT_TUSER_BITS-1:0] {
    EV_PRESSED  = 2'd0,
    EV_RELEASED = 2'd1,
    EV_LONG     = 2'd2,
    EV_REPEAT   = 2'd3
  } ev_kind_t;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_POLARITY     = 3'd0,
    REG_DEBOUNCE     = 3'd1,
    REG_LONG_PRESS   = 3'd2,
    REG_REPEAT       = 3'd3,
    REG_KEY_MARKER   = 3'd4
  } reg_idx_t;

  localparam cfg_ticks_t DEBOUNCE_RESET = cfg_ticks_t'(20000);

endpackage : kdlpr_pkg

`default_nettype wire

/* rtl/core/key_debounce_long_press_repeat.sv */
// Top level of the key debounce block with long-press and auto-repeat events.
// Depends on kdlpr_pkg for widths, event kinds and register indexes.
//
// Usage:
//   The in_ stream carries one word per tick with the raw key pin level in bit 0.
//   The first word after reset only primes the stored level and debounced state.
//   Later level changes restart the debounce countdown; on expiry a pressed or
//   released event is reported. A press starts the long-press countdown if one is set;
//   its expiry reports a long press and, if a repeat period is set, starts periodic repeat events.
//   The out_ stream carries at most one event word per input word: tuser holds
//   the event kind, tdata the debounced state and the configured key marker.
//   An event is valid in the cycle after its tick is taken.
//   Throughput is one tick per cycle while out_ does not stall; the whole update is one pass of counter
//   decrement and compare logic between the state registers.
//   The output register lets a new tick be taken in the same cycle the pending
//   event is taken; while the receiver stalls with an event pending, in_tready
//   stays low and no tick is taken.
//   Reset (rst_n low, synchronous) clears key state and the valid flag and loads register
//   defaults: active low, 20000 debounce ticks, long press and repeat off, marker zero.
//   The user writes registers via the APB port only while the block is idle (not enforced).
`timescale 1ns / 1ps
`default_nettype none

module key_debounce_long_press_repeat
  import kdlpr_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Input stream
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [IN_TDATA_BITS-1:0]  in_tdata,    // [0] pin_level, [7:1] zero
  // Result stream
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0]      out_tdata,   // [0] pressed_state, [32:1] event_marker
  output logic [OUT_TUSER_BITS-1:0]      out_tuser,   // [1:0] event_kind
  // Configuration port
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [APB_ADDR_BITS-1:0]  cfg_paddr,
  input  wire logic [APB_DATA_BITS-1:0]  cfg_pwdata,
  output logic [APB_DATA_BITS-1:0]       cfg_prdata,
  output logic                           cfg_pready
);

  // Configuration registers
  logic                   pol_low_r;
  cfg_ticks_t             debounce_ticks_r;
  cfg_ticks_t             long_press_ticks_r;
  cfg_ticks_t             repeat_ticks_r;
  logic [MARKER_BITS-1:0] key_marker_r;

  // Key state
  logic primed_r,   primed_nxt;
  logic prev_r,     prev_nxt;
  logic deb_r,      deb_nxt;
  logic darm_r,     darm_nxt;
  cnt_t dleft_r,    dleft_nxt;
  logic larm_r,     larm_nxt;
  cnt_t lleft_r,    lleft_nxt;
  logic rarm_r,     rarm_nxt;
  cnt_t rleft_r,    rleft_nxt;

  // Result register
  logic                   out_valid_r;
  ev_kind_t               out_kind_r;
  logic                   out_state_r;
  logic [MARKER_BITS-1:0] out_marker_r;

  logic     in_acc;
  logic     cfg_wr;
  logic     level;
  logic     fired;
  logic     emit;
  ev_kind_t kind;
  reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[APB_ADDR_BITS-1:2]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_low_r          <= 1'b1;
      debounce_ticks_r   <= DEBOUNCE_RESET;
      long_press_ticks_r <= '0;
      repeat_ticks_r     <= '0;
      key_marker_r       <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_POLARITY:   pol_low_r          <= cfg_pwdata[0];
        REG_DEBOUNCE:   debounce_ticks_r   <= cfg_pwdata[CFG_BITS-1:0];
        REG_LONG_PRESS: long_press_ticks_r <= cfg_pwdata[CFG_BITS-1:0];
        REG_REPEAT:     repeat_ticks_r     <= cfg_pwdata[CFG_BITS-1:0];
        REG_KEY_MARKER: key_marker_r       <= cfg_pwdata[MARKER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (cfg_idx)
      REG_POLARITY:   cfg_prdata = APB_DATA_BITS'(pol_low_r);
      REG_DEBOUNCE:   cfg_prdata = APB_DATA_BITS'(debounce_ticks_r);
      REG_LONG_PRESS: cfg_prdata = APB_DATA_BITS'(long_press_ticks_r);
      REG_REPEAT:     cfg_prdata = APB_DATA_BITS'(repeat_ticks_r);
      REG_KEY_MARKER: cfg_prdata = APB_DATA_BITS'(key_marker_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // A tick is taken whenever the result register is empty or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign level     = in_tdata[0];

  // One pass of the key state update for the incoming tick.
  always_comb begin
    primed_nxt = primed_r;
    prev_nxt   = prev_r;
    deb_nxt    = deb_r;
    darm_nxt   = darm_r;
    dleft_nxt  = dleft_r;
    larm_nxt   = larm_r;
    lleft_nxt  = lleft_r;
    rarm_nxt   = rarm_r;
    rleft_nxt  = rleft_r;
    fired      = 1'b0;
    emit       = 1'b0;
    kind       = EV_PRESSED;

    if (!primed_r) begin
      // First tick only primes the level and the debounced state.
      primed_nxt = 1'b1;
      prev_nxt   = level;
      deb_nxt    = level ^ pol_low_r;
    end else begin
      // Edge restarts debounce and cancels long press and repeat.
      if (level != prev_r) begin
        prev_nxt  = level;
        darm_nxt  = 1'b1;
        dleft_nxt = cnt_t'(debounce_ticks_r);
        larm_nxt  = 1'b0;
        rarm_nxt  = 1'b0;
        fired     = (dleft_nxt == '0);
      end else if (darm_r) begin
        if (dleft_r != '0) begin
          dleft_nxt = dleft_r - cnt_t'(1);
        end
        fired = (dleft_nxt == '0);
      end

      if (darm_nxt && fired) begin
        // Debounce expired: sample the level and report press or release.
        darm_nxt = 1'b0;
        deb_nxt  = level ^ pol_low_r;
        larm_nxt = 1'b0;
        rarm_nxt = 1'b0;
        emit     = 1'b1;
        if (deb_nxt) begin
          kind = EV_PRESSED;
          if (long_press_ticks_r != '0) begin
            larm_nxt  = 1'b1;
            lleft_nxt = cnt_t'(long_press_ticks_r);
          end
        end else begin
          kind = EV_RELEASED;
        end
      end else if (larm_nxt) begin
        // Long-press countdown; its expiry starts the repeat period when one is set.
        if (lleft_r != '0) begin
          lleft_nxt = lleft_r - cnt_t'(1);
        end
        if (lleft_nxt == '0) begin
          larm_nxt = 1'b0;
          emit     = 1'b1;
          kind     = EV_LONG;
          if (repeat_ticks_r != '0) begin
            rarm_nxt  = 1'b1;
            rleft_nxt = cnt_t'(repeat_ticks_r);
          end
        end
      end else if (rarm_nxt) begin
        // Repeat countdown reloads itself on every expiry.
        if (rleft_r != '0) begin
          rleft_nxt = rleft_r - cnt_t'(1);
        end
        if (rleft_nxt == '0) begin
          rleft_nxt = cnt_t'(repeat_ticks_r);
          emit      = 1'b1;
          kind      = EV_REPEAT;
        end
      end
    end
  end

  // Key state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
      prev_r   <= 1'b0;
      deb_r    <= 1'b0;
      darm_r   <= 1'b0;
      dleft_r  <= '0;
      larm_r   <= 1'b0;
      lleft_r  <= '0;
      rarm_r   <= 1'b0;
      rleft_r  <= '0;
    end else if (in_acc) begin
      primed_r <= primed_nxt;
      prev_r   <= prev_nxt;
      deb_r    <= deb_nxt;
      darm_r   <= darm_nxt;
      dleft_r  <= dleft_nxt;
      larm_r   <= larm_nxt;
      lleft_r  <= lleft_nxt;
      rarm_r   <= rarm_nxt;
      rleft_r  <= rleft_nxt;
    end
  end

  // Result register: valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register: payload, loaded with every event.
  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_kind_r   <= kind;
      out_state_r  <= deb_nxt;
      out_marker_r <= key_marker_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {(OUT_TDATA_BITS - MARKER_BITS - 1)'(0), out_marker_r, out_state_r};

  // Nothing is reported before the priming word.
  a_no_event_unprimed: assert property (@(posedge clk) disable iff (!rst_n)
    !primed_r |-> !out_valid_r)
    else $error("event reported before priming");

  // Long press and repeat countdowns are never armed together.
  a_long_repeat_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(larm_r && rarm_r))
    else $error("long press and repeat armed together");

  // A release always reports the key as not pressed.
  a_release_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == EV_RELEASED) |-> !out_state_r)
    else $error("release event with key pressed");

  // Press, long press and repeat events all report the key as pressed.
  a_held_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == EV_PRESSED || out_kind_r == EV_LONG ||
                     out_kind_r == EV_REPEAT)) |-> out_state_r)
    else $error("held-key event with key released");

  // Long press and repeat are only armed while the debounced key is pressed.
  a_armed_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (larm_r || rarm_r) |-> deb_r)
    else $error("countdown armed while key released");

endmodule : key_debounce_long_press_repeat

`default_nettype wire

/* tb/sv/tb_key_debounce_long_press_repeat.sv */
// Self-checking testbench for the key debounce block with long press and auto-repeat.
// Depends on kdlpr_pkg and key_debounce_long_press_repeat; an in-file tracker predicts events.
`timescale 1ns / 1ps

module tb_key_debounce_long_press_repeat;
  import kdlpr_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int IDLE_PCT    = 32;
  localparam logic [REG_IDX_BITS-1:0] SPARE_REG = 3'd5;

  // One reported key event as it appears on the result stream.
  typedef struct packed {
    ev_kind_t               kind;
    logic                   pressed;
    logic [MARKER_BITS-1:0] marker;
  } key_event_t;

  // Tracks the key state and configuration, and holds the events still awaited.
  class key_event_tracker;
    bit                   pol_low        = 1'b1;
    bit [CFG_BITS-1:0]    debounce_ticks = DEBOUNCE_RESET;
    bit [CFG_BITS-1:0]    long_ticks     = '0;
    bit [CFG_BITS-1:0]    repeat_ticks   = '0;
    bit [MARKER_BITS-1:0] key_marker     = '0;

    bit primed, prev_level, debounced;
    bit settle_armed, long_armed, repeat_armed;
    bit [COUNT_BITS-1:0] settle_left, long_left, repeat_left;

    key_event_t awaited_events[$];
    int mismatches = 0;

    task report(string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
    endtask

    function void set_register(logic [REG_IDX_BITS-1:0] idx, logic [APB_DATA_BITS-1:0] value);
      case (idx)
        REG_POLARITY:   pol_low        = value[0];
        REG_DEBOUNCE:   debounce_ticks = value[CFG_BITS-1:0];
        REG_LONG_PRESS: long_ticks     = value[CFG_BITS-1:0];
        REG_REPEAT:     repeat_ticks   = value[CFG_BITS-1:0];
        REG_KEY_MARKER: key_marker     = value;
        default: ;
      endcase
    endfunction

    function logic [APB_DATA_BITS-1:0] register_value(logic [REG_IDX_BITS-1:0] idx);
      case (idx)
        REG_POLARITY:   return APB_DATA_BITS'(pol_low);
        REG_DEBOUNCE:   return APB_DATA_BITS'(debounce_ticks);
        REG_LONG_PRESS: return APB_DATA_BITS'(long_ticks);
        REG_REPEAT:     return APB_DATA_BITS'(repeat_ticks);
        default:        return key_marker;
      endcase
    endfunction

    // Counts one tick down and tells whether the countdown has run out.
    function bit count_down(inout bit [COUNT_BITS-1:0] left);
      if (left != 0) left = left - 1'b1;
      return left == 0;
    endfunction

    function void push_event(ev_kind_t kind);
      key_event_t ev;
      ev.kind    = kind;
      ev.pressed = debounced;
      ev.marker  = key_marker;
      awaited_events.push_back(ev);
    endfunction

    // Advances the key state by one accepted tick word.
    function void take_tick(bit level);
      bit fired;
      fired = 1'b0;
      if (!primed) begin
        primed     = 1'b1;
        prev_level = level;
        debounced  = level ^ pol_low;
        return;
      end
      // Any edge restarts the debounce wait and cancels long press and repeat.
      if (level != prev_level) begin
        prev_level   = level;
        settle_armed = 1'b1;
        settle_left  = debounce_ticks;
        long_armed   = 1'b0;
        repeat_armed = 1'b0;
        fired        = (settle_left == 0);
      end else if (settle_armed) begin
        fired = count_down(settle_left);
      end
      if (settle_armed && fired) begin
        settle_armed = 1'b0;
        debounced    = level ^ pol_low;
        long_armed   = 1'b0;
        repeat_armed = 1'b0;
        if (debounced) begin
          if (long_ticks != 0) begin
            long_armed = 1'b1;
            long_left  = long_ticks;
          end
          push_event(EV_PRESSED);
        end else begin
          push_event(EV_RELEASED);
        end
        return;
      end
      if (long_armed) begin
        if (count_down(long_left)) begin
          long_armed = 1'b0;
          if (repeat_ticks != 0) begin
            repeat_armed = 1'b1;
            repeat_left  = repeat_ticks;
          end
          push_event(EV_LONG);
        end
        return;
      end
      if (repeat_armed && count_down(repeat_left)) begin
        repeat_left = repeat_ticks;
        push_event(EV_REPEAT);
      end
    endfunction

    // Compares one accepted event word with the oldest awaited event.
    task match_event(ev_kind_t kind, logic pressed, logic [MARKER_BITS-1:0] marker);
      key_event_t want;
      if (awaited_events.size() == 0) begin
        report($sformatf("event %s arrived with none awaited", kind.name()));
        return;
      end
      want = awaited_events.pop_front();
      if (kind !== want.kind)
        report($sformatf("kind %s, awaited %s", kind.name(), want.kind.name()));
      if (pressed !== want.pressed)
        report($sformatf("pressed state %b, awaited %b", pressed, want.pressed));
      if (marker !== want.marker)
        report($sformatf("marker %h, awaited %h", marker, want.marker));
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata;   // [0] pin_level, [7:1] zero
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_TDATA_BITS-1:0] out_tdata;  // [0] pressed_state, [32:1] event_marker
  logic [OUT_TUSER_BITS-1:0] out_tuser;  // [1:0] event_kind
  logic                      cfg_psel;
  logic                      cfg_penable;
  logic                      cfg_pwrite;
  logic [APB_ADDR_BITS-1:0]  cfg_paddr;
  logic [APB_DATA_BITS-1:0]  cfg_pwdata;
  logic [APB_DATA_BITS-1:0]  cfg_prdata;
  logic                      cfg_pready;

  key_event_tracker tracker = new();
  bit calm      = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  key_debounce_long_press_repeat DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Both streams are observed at the rising edge; an event leaving now belongs to an
  // earlier tick, so it is checked before the tick taken at the same edge is applied.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        tracker.match_event(ev_kind_t'(out_tuser), out_tdata[0], out_tdata[MARKER_BITS:1]);
      if (in_tvalid && in_tready)
        tracker.take_tick(in_tdata[0]);
    end
  end

  // The run is abandoned after too many cycles in which no word moves.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_key_debounce_long_press_repeat: errors");
      $finish;
    end
  end

  // Result side: random stalls, and one long hold-off that backs up the input.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Offers one tick word after a random gap and waits until it is taken.
  task send_tick(bit level);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_BITS-1){1'b0}}, level};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Sends the low n bits of a pattern, lowest bit first.
  task send_pattern(logic [31:0] levels, int n);
    for (int i = 0; i < n; i++) send_tick(levels[i]);
  endtask

  // Stops offering ticks and lets every awaited event drain out of the block.
  task settle();
    in_tvalid <= 1'b0;
    while (tracker.awaited_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes one register, then reads it back where it exists.
  task write_reg(logic [REG_IDX_BITS-1:0] idx, logic [APB_DATA_BITS-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    tracker.set_register(idx, value);
    @(negedge clk);
    if (idx <= REG_KEY_MARKER) begin
      cfg_psel    <= 1'b1;
      cfg_pwrite  <= 1'b0;
      @(negedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
      if (cfg_prdata !== tracker.register_value(idx))
        tracker.report($sformatf("register %0d reads %h, holds %h", idx, cfg_prdata,
                                 tracker.register_value(idx)));
      @(negedge clk);
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      @(negedge clk);
    end
  endtask

  task set_all(bit pl, logic [CFG_BITS-1:0] db, logic [CFG_BITS-1:0] lp,
               logic [CFG_BITS-1:0] rp, logic [MARKER_BITS-1:0] mk);
    write_reg(REG_POLARITY, APB_DATA_BITS'(pl));
    write_reg(REG_DEBOUNCE, APB_DATA_BITS'(db));
    write_reg(REG_LONG_PRESS, APB_DATA_BITS'(lp));
    write_reg(REG_REPEAT, APB_DATA_BITS'(rp));
    write_reg(REG_KEY_MARKER, mk);
  endtask

  // Mostly key presses and releases with contact bounce, held for random spans that can
  // reach long press and repeat; the rest is random chatter.
  task drive_phase(int n_items);
    int sent;
    int span;
    bit lvl;
    sent = 0;
    lvl  = tracker.prev_level;
    span = tracker.debounce_ticks + tracker.long_ticks + 4 * tracker.repeat_ticks + 4;
    if (span > 40) span = 40;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) != 0) begin
        lvl = !lvl;
        repeat ($urandom_range(0, 3)) begin
          send_tick(1'($urandom_range(0, 1)));
          sent++;
        end
        repeat ($urandom_range(1, span)) begin
          send_tick(lvl);
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_tick(1'($urandom_range(0, 1)));
          sent++;
        end
        lvl = tracker.prev_level;
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Priming tick, then edges well inside the reset debounce time: no events.
    send_pattern(32'b101, 3);
    settle();

    // Zero debounce reports on the edge tick; long press after two ticks, then repeats.
    set_all(1'b0, 24'd0, 24'd2, 24'd1, 32'h8000_0000);
    send_pattern(32'b0111110, 7);
    settle();

    // Reach the repeat phase, then clear the repeat period while it is running.
    set_all(1'b0, 24'd2, 24'd1, 24'd3, 32'h7FFF_FFFF);
    send_pattern(32'b11111, 5);
    settle();
    set_all(1'b0, 24'd2, 24'd1, 24'd0, 32'h7FFF_FFFF);
    send_pattern(32'b0111, 4);
    settle();

    // A write past the last register is ignored; flipping polarity only affects the
    // sample taken when the pending debounce runs out.
    write_reg(SPARE_REG, $urandom);
    set_all(1'b1, 24'd2, 24'd0, 24'd0, 32'hA5A5_5A5A);
    send_pattern(32'b000, 3);
    settle();

    // Largest countdowns: edges restart a debounce that never runs out here.
    set_all(1'b1, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF);
    send_pattern(32'b0101, 4);
    settle();

    // Random phases with short countdowns; one backs up the input, one runs without gaps.
    for (int ph = 0; ph < 11; ph++) begin
      if (ph == 3)
        set_all(1'b0, 24'd0, 24'd1, 24'd1, $urandom);
      else
        set_all(1'($urandom_range(0, 1)), CFG_BITS'($urandom_range(0, 6)),
                CFG_BITS'($urandom_range(0, 8)), CFG_BITS'($urandom_range(0, 4)),
                $urandom);
      calm     = (ph == 6);
      hold_req = (ph == 3);
      drive_phase(90);
      settle();
      calm = 1'b0;
    end

    repeat (4) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("tb_key_debounce_long_press_repeat: clean");
    end else begin
      $display("tb_key_debounce_long_press_repeat: errors");
    end
    $finish;
  end

endmodule
